### hdl/erp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erp_pkg;

  localparam int MAX_RECORDS = 8;
  localparam int SLOT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W = SLOT_W + 1;

  localparam logic [31:0] HDR_MAGIC = 32'h5254_4152;
  localparam logic [7:0] REPORT_REV = 8'd1;

  localparam logic [1:0] TYPE_BATTERY = 2'd1;
  localparam logic [1:0] TYPE_BAIT = 2'd2;
  localparam logic [1:0] TYPE_TRAP = 2'd3;

  localparam logic [7:0] LEN_SHORT = 8'd2;
  localparam logic [7:0] LEN_LONG = 8'd4;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_DEVICE_ID = 1'b0;

  typedef enum logic [1:0] {
    MODE_BATTERY = 2'd0,
    MODE_BAIT    = 2'd1,
    MODE_TRAP    = 2'd2,
    MODE_SEND    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD,
    ST_REC
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] timestamp;
    logic [15:0] level;
    logic [15:0] bait_id;
    logic [31:0] open_stamp;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  rtype;
    logic [31:0] payload;
  } rec_t;

  // A piece of the report: len bytes from the low end of data.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  len;
    logic        last;
  } chunk_t;

endpackage

`default_nettype wire

### hdl/erp_store.sv
`timescale 1ns / 1ps
`default_nettype none

module erp_store
  import erp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire rec_t              wdata,
  input  wire logic              re,
  input  wire logic [SLOT_W-1:0] raddr,
  output rec_t                   rdata
);

  rec_t mem [MAX_RECORDS];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/erp_packer.sv
`timescale 1ns / 1ps
`default_nettype none

module erp_packer
  import erp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      chunk_valid,
  input  wire chunk_t    chunk,
  output logic           chunk_ready,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [55:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        flush_r, flush_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic        out_free;
  logic [55:0] merged;
  logic [2:0]  total;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    chunk_ready = out_free && !flush_r;
    merged = acc_r | ({24'b0, chunk.data} << {cnt_r, 3'b000});
    total = {1'b0, cnt_r} + chunk.len;

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    flush_nxt = flush_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (flush_r && out_free) begin
      out_nxt.data_word = acc_r[31:0];
      out_nxt.byte_count = {1'b0, cnt_r};
      out_nxt.last = 1'b1;
      out_valid_nxt = 1'b1;
      acc_nxt = '0;
      cnt_nxt = '0;
      flush_nxt = 1'b0;
    end else if (chunk_valid && chunk_ready) begin
      if (total >= 3'd4) begin
        out_nxt.data_word = merged[31:0];
        out_nxt.byte_count = 3'd4;
        out_nxt.last = chunk.last && (total == 3'd4);
        out_valid_nxt = 1'b1;
        acc_nxt = merged >> 32;
        cnt_nxt = total[1:0];
        flush_nxt = chunk.last && (total != 3'd4);
      end else if (chunk.last) begin
        out_nxt.data_word = merged[31:0];
        out_nxt.byte_count = total;
        out_nxt.last = 1'b1;
        out_valid_nxt = 1'b1;
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = merged;
        cnt_nxt = total[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      flush_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      flush_r <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

### hdl/event_record_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// Add items (modes 0..2): the record is written at the accept edge.
// A send emits five header pieces, then per record one memory read and four pieces,
// each piece limited by the output register. The report is 4 to 24 words.
// Reset (synchronous, rst_n low) empties the store and clears device_id; record
// memory contents are left as they are and are never read before being written.
module event_record_packer
  import erp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  state_t             state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [SLOT_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]   rec_idx_r, rec_idx_nxt;
  logic [31:0]        send_time_r, send_time_nxt;
  logic [31:0]        device_id_r;

  logic               in_acc;
  logic               full;
  logic [SUM_W-1:0]   tail_sum;
  logic [SLOT_W-1:0]  tail_slot;
  logic [SLOT_W-1:0]  oldest_inc;
  logic [SLOT_W-1:0]  rd_slot_inc;
  logic               rec_last;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  rec_t               mem_wdata;
  logic               mem_re;
  rec_t               mem_rdata;

  logic               chunk_valid;
  chunk_t             chunk;
  logic               chunk_ready;

  logic               cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    if (cfg_paddr[2] == REG_DEVICE_ID) begin
      cfg_prdata = device_id_r;
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_DEVICE_ID) begin
      device_id_r <= cfg_pwdata;
    end
  end

  erp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_slot_r),
    .rdata (mem_rdata)
  );

  erp_packer u_packer (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_valid (chunk_valid),
    .chunk       (chunk),
    .chunk_ready (chunk_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    in_acc = in_valid && !in_stall;
    full = (count_r == CNT_W'(MAX_RECORDS));

    tail_sum = SUM_W'(oldest_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(MAX_RECORDS)) begin
      tail_sum = tail_sum - SUM_W'(MAX_RECORDS);
    end
    tail_slot = tail_sum[SLOT_W-1:0];

    oldest_inc = (oldest_r == SLOT_W'(MAX_RECORDS - 1)) ? '0 : oldest_r + 1'b1;
    rd_slot_inc = (rd_slot_r == SLOT_W'(MAX_RECORDS - 1)) ? '0 : rd_slot_r + 1'b1;
    rec_last = ((rec_idx_r + 1'b1) == count_r);

    state_nxt = state_r;
    step_nxt = step_r;
    oldest_nxt = oldest_r;
    count_nxt = count_r;
    rd_slot_nxt = rd_slot_r;
    rec_idx_nxt = rec_idx_r;
    send_time_nxt = send_time_r;

    mem_we = 1'b0;
    mem_waddr = full ? oldest_r : tail_slot;
    mem_wdata.stamp = in_data.timestamp;
    mem_wdata.rtype = in_data.mode + 2'd1;
    mem_re = 1'b0;
    chunk_valid = 1'b0;
    chunk = '0;

    case (mode_t'(in_data.mode))
      MODE_BATTERY: mem_wdata.payload = {16'b0, in_data.level};
      MODE_BAIT:    mem_wdata.payload = {in_data.level, in_data.bait_id};
      default:      mem_wdata.payload = in_data.open_stamp;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_t'(in_data.mode) == MODE_SEND) begin
            send_time_nxt = in_data.timestamp;
            rd_slot_nxt = oldest_r;
            rec_idx_nxt = '0;
            step_nxt = '0;
            state_nxt = ST_HDR;
          end else begin
            mem_we = 1'b1;
            if (full) begin
              oldest_nxt = oldest_inc;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      ST_HDR: begin
        chunk_valid = 1'b1;
        case (step_r)
          3'd0: begin
            chunk.data = HDR_MAGIC;
            chunk.len = 3'd4;
          end
          3'd1: begin
            chunk.data = {24'b0, REPORT_REV};
            chunk.len = 3'd1;
          end
          3'd2: begin
            chunk.data = device_id_r;
            chunk.len = 3'd4;
          end
          3'd3: begin
            chunk.data = send_time_r;
            chunk.len = 3'd4;
          end
          default: begin
            chunk.data = 32'(count_r);
            chunk.len = 3'd1;
            chunk.last = (count_r == '0);
          end
        endcase
        if (chunk_ready) begin
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd4) begin
            step_nxt = '0;
            state_nxt = (count_r == '0) ? ST_IDLE : ST_RD;
          end
        end
      end
      ST_RD: begin
        mem_re = 1'b1;
        step_nxt = '0;
        state_nxt = ST_REC;
      end
      ST_REC: begin
        chunk_valid = 1'b1;
        case (step_r)
          3'd0: begin
            chunk.data = {30'b0, mem_rdata.rtype};
            chunk.len = 3'd1;
          end
          3'd1: begin
            chunk.data = mem_rdata.stamp;
            chunk.len = 3'd4;
          end
          3'd2: begin
            chunk.data = {24'b0, (mem_rdata.rtype == TYPE_BATTERY) ? LEN_SHORT : LEN_LONG};
            chunk.len = 3'd1;
          end
          default: begin
            if (mem_rdata.rtype == TYPE_BATTERY) begin
              chunk.data = {16'b0, mem_rdata.payload[15:0]};
              chunk.len = 3'd2;
            end else begin
              chunk.data = mem_rdata.payload;
              chunk.len = 3'd4;
            end
            chunk.last = rec_last;
          end
        endcase
        if (chunk_ready) begin
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd3) begin
            step_nxt = '0;
            if (rec_last) begin
              state_nxt = ST_IDLE;
            end else begin
              rec_idx_nxt = rec_idx_r + 1'b1;
              rd_slot_nxt = rd_slot_inc;
              state_nxt = ST_RD;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      oldest_r <= '0;
      count_r <= '0;
      rd_slot_r <= '0;
      rec_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      oldest_r <= oldest_nxt;
      count_r <= count_nxt;
      rd_slot_r <= rd_slot_nxt;
      rec_idx_r <= rec_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    send_time_r <= send_time_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  a_no_write_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("record store written during a report");

  a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_t'(in_data.mode) == MODE_SEND) |=> (state_r == ST_HDR && step_r == 3'd0))
    else $error("send did not start the header");

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.byte_count == 3'd4))
    else $error("short word before the end of a report");
`endif

endmodule

`default_nettype wire

### dv/event_record_packer_tb.sv
`timescale 1ns / 1ps
module event_record_packer_tb;
  import erp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTS = 40;
  localparam logic [CFG_ADDR_W-1:0] DEVICE_ID_ADDR = CFG_ADDR_W'(4 * int'(REG_DEVICE_ID));

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  event_record_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Shadow of the record store and the unit id
  logic [31:0] shadow_stamp [MAX_RECORDS];
  logic [1:0]  shadow_kind [MAX_RECORDS];
  logic [31:0] shadow_payload [MAX_RECORDS];
  int unsigned shadow_head = 0;
  int unsigned shadow_held = 0;
  logic [31:0] unit_id = '0;

  in_item_t    pending_items[$];
  out_item_t   report_words[$];
  logic [7:0]  report_bytes[$];

  int mismatches = 0;
  int items_taken = 0;
  int reports_sent = 0;
  int words_checked = 0;
  int ids_used = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic append_le(input logic [31:0] v, input int n);
    for (int b = 0; b < n; b++)
      report_bytes.push_back(v[8*b +: 8]);
  endtask

  task automatic store_event(input logic [31:0] stamp, input logic [1:0] kind,
                             input logic [31:0] payload);
    int unsigned slot;
    if (shadow_held >= MAX_RECORDS) begin
      // drop the oldest record
      slot = shadow_head;
      shadow_head = (shadow_head + 1) % MAX_RECORDS;
    end else begin
      slot = (shadow_head + shadow_held) % MAX_RECORDS;
      shadow_held++;
    end
    shadow_stamp[slot] = stamp;
    shadow_kind[slot] = kind;
    shadow_payload[slot] = payload;
  endtask

  task automatic predict_item(input in_item_t it);
    int unsigned slot;
    int unsigned nbytes;
    int unsigned cnt;
    out_item_t w;
    case (mode_t'(it.mode))
      MODE_BATTERY: store_event(it.timestamp, TYPE_BATTERY, {16'h0, it.level});
      MODE_BAIT:    store_event(it.timestamp, TYPE_BAIT, {it.level, it.bait_id});
      MODE_TRAP:    store_event(it.timestamp, TYPE_TRAP, it.open_stamp);
      default: begin
        reports_sent++;
        report_bytes.delete();
        append_le(HDR_MAGIC, 4);
        append_le({24'h0, REPORT_REV}, 1);
        append_le(unit_id, 4);
        append_le(it.timestamp, 4);
        append_le(shadow_held, 1);
        for (int r = 0; r < shadow_held; r++) begin
          slot = (shadow_head + r) % MAX_RECORDS;
          append_le({30'h0, shadow_kind[slot]}, 1);
          append_le(shadow_stamp[slot], 4);
          if (shadow_kind[slot] == TYPE_BATTERY) begin
            append_le({24'h0, LEN_SHORT}, 1);
            append_le(shadow_payload[slot], 2);
          end else begin
            append_le({24'h0, LEN_LONG}, 1);
            append_le(shadow_payload[slot], 4);
          end
        end
        nbytes = report_bytes.size();
        for (int base = 0; base < nbytes; base += 4) begin
          cnt = (nbytes - base > 4) ? 4 : nbytes - base;
          w = '0;
          for (int b = 0; b < cnt; b++)
            w.data_word[8*b +: 8] = report_bytes[base + b];
          w.byte_count = 3'(cnt);
          w.last = (base + 4 >= nbytes);
          report_words.push_back(w);
        end
      end
    endcase
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0 && !quiet) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0)
            tx_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    bit stall_next;
    stall_next = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (report_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h count %0d last %0b",
                                  out_data.data_word, out_data.byte_count, out_data.last));
        end else begin
          want = report_words.pop_front();
          if (out_data.data_word !== want.data_word || out_data.byte_count !== want.byte_count
              || out_data.last !== want.last)
            flag_mismatch($sformatf("word %h/%0d/%0b, expected %h/%0d/%0b",
                                    out_data.data_word, out_data.byte_count, out_data.last,
                                    want.data_word, want.byte_count, want.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req && !hold_done) begin
        // long hold: let the block back up into its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall_next = 1'b1;
      end else if (rx_gap > 0 && !quiet) begin
        rx_gap--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 19);
      end
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_unit_id(input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= DEVICE_ID_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    unit_id = v;
    ids_used++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() > 0 || in_valid || report_words.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t make_item(mode_t m, logic [31:0] ts, logic [15:0] lvl,
                                         logic [15:0] bid, logic [31:0] opened);
    in_item_t it;
    it.mode = m;
    it.timestamp = ts;
    it.level = lvl;
    it.bait_id = bid;
    it.open_stamp = opened;
    return it;
  endfunction

  function automatic in_item_t rand_item(mode_t m);
    return make_item(m, $urandom, 16'($urandom), 16'($urandom), $urandom);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(input int n);
    mode_t m;
    for (int k = 0; k < n; k++) begin
      m = ($urandom_range(0, 3) == 0) ? MODE_SEND : mode_t'($urandom_range(0, 2));
      pending_items.push_back(make_item(m, pick_word(), 16'(pick_word()), 16'(pick_word()),
                                        pick_word()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_unit_id(32'hFFFF_FFFF);
    // empty store: header only
    pending_items.push_back(make_item(MODE_SEND, 32'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_SEND, 32'hFFFF_FFFF, 16'h0, 16'h0, 32'h0));
    pending_items.push_back(make_item(MODE_BATTERY, 32'hFFFF_FFFF, 16'hFFFF, 16'hA5A5,
                                      32'h5A5A_5A5A));
    pending_items.push_back(make_item(MODE_BAIT, 32'h0, 16'h0, 16'hFFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_TRAP, 32'h1234_5678, 16'hFFFF, 16'hFFFF,
                                      32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_SEND, 32'h8000_0001, 16'hFFFF, 16'hFFFF,
                                      32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_BATTERY, 32'h0, 16'h0, 16'hFFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_BAIT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 32'h0));
    pending_items.push_back(make_item(MODE_TRAP, 32'h0, 16'h0, 16'h0, 32'h0));
    pending_items.push_back(rand_item(MODE_BATTERY));
    pending_items.push_back(rand_item(MODE_BAIT));
    // store is full now
    pending_items.push_back(rand_item(MODE_SEND));
    pending_items.push_back(rand_item(MODE_TRAP));
    pending_items.push_back(rand_item(MODE_BATTERY));
    pending_items.push_back(rand_item(MODE_SEND));
    for (int k = 0; k < 7; k++)
      pending_items.push_back(rand_item(mode_t'(k % 3)));
    // back-to-back sends: sending keeps the records
    pending_items.push_back(rand_item(MODE_SEND));
    pending_items.push_back(rand_item(MODE_SEND));
    wait_drained();

    write_unit_id(32'h0);
    hold_req = 1'b1;
    queue_random(60);
    wait_drained();

    write_unit_id($urandom);
    queue_random(70);
    wait_drained();

    // closing stretch without idling on either side
    write_unit_id($urandom);
    quiet = 1'b1;
    queue_random(60);
    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    if (report_words.size() > 0)
      flag_mismatch($sformatf("%0d report words never arrived", report_words.size()));
    $display("run: %0d items accepted, %0d reports, %0d words checked, %0d unit ids",
             items_taken, reports_sent, words_checked, ids_used);
    $display("     store overflow, empty-store reports and a %0d-cycle output hold included",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
hdl/erp_pkg.sv
hdl/erp_store.sv
hdl/erp_packer.sv
hdl/event_record_packer.sv
dv/event_record_packer_tb.sv
